// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mbd_pkg.sv =====
package mbd_pkg;

    localparam int PIX_W         = 8;
    localparam int LANE_W        = 9;
    localparam int NUM_LANES     = 4;
    localparam int CFG_W         = 13;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int HGT_W         = 13;
    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SINGLE_CH  = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] chan0_in;
        logic [PIX_W-1:0] chan1_in;
        logic [PIX_W-1:0] chan2_in;
        logic [PIX_W-1:0] chan3_in;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] chan0_out;
        logic [PIX_W-1:0] chan1_out;
        logic [PIX_W-1:0] chan2_out;
        logic [PIX_W-1:0] chan3_out;
        logic             level_done;
    } pixel_out_t;

    typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

    // per-lane add, each lane wraps at its own width
    function automatic lanes_t lane_add(input lanes_t a, input lanes_t b);
        lanes_t r;
        for (int c = 0; c < NUM_LANES; c++)
        begin
            r[c] = a[c] + b[c];
        end
        return r;
    endfunction

endpackage

// ===== rtl/mipmap_box_downsample.sv =====
// 2x2 box-filter mip level generator. Source pixels arrive one per transfer on the src
// channel in raster order; each output pixel on the dst channel is the per-channel sum of a
// 2x2 source block shifted right by two, so the output level is floor(w/2) x floor(h/2) and
// an odd last column or row is consumed without output. level_done marks the final output
// pixel of a level, after which the next source pixel starts a new level of the same size.
// Registers (APB, byte addresses): 0x0 src_width (2..MAX_WIDTH, clamped), 0x4 src_height
// (2..4096, clamped), 0x8 single_channel (only channel 0 is carried, the other output
// channels read zero). Any register write restarts the level; write only while idle.
// Throughput is one source pixel per clock while the output is not stalled; an output
// pixel passes the first stage and the output register after the transfer of the odd-row
// odd-column pixel that completes it. The line store takes one write (even rows) or one
// read (odd rows) per clock, holds MAX_WIDTH/2 pair sums, needs no clearing after reset.
module mipmap_box_downsample #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    output logic                         src_ready,
    input  mbd_pkg::pixel_in_t           src_pixel,
    output logic                         dst_valid,
    input  logic                         dst_ready,
    output mbd_pkg::pixel_out_t          dst_pixel,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbd_pkg::PADDR_W-1:0]  paddr,
    input  logic [mbd_pkg::PDATA_W-1:0]  pwdata,
    output logic [mbd_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    import mbd_pkg::*;

    // line store addressing: one entry per horizontal pixel pair
    localparam int ADDR_W     = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = ADDR_W + 1;
    localparam int W_W        = COL_W + 1;
    localparam int EXT_W      = (W_W > CFG_W) ? W_W : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             single_reg;

    // position and held even-column pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    lanes_t           hold_reg, hold_next;

    // first stage: pair sum of the odd row and the line store read
    logic             s1_vld_reg, s1_vld_next;
    lanes_t           pair_reg;
    lanes_t           above_reg;
    logic             last_reg;

    // output register
    logic             dst_valid_reg, dst_valid_next;
    pixel_out_t       dst_reg;

    lanes_t           line_mem [LINE_DEPTH];

    logic             cfg_wr;
    logic [1:0]       cfg_idx;
    logic             restart;

    logic [EXT_W-1:0] w_ext;
    logic [W_W-1:0]   w_eff;
    logic [W_W-1:0]   w_even;
    logic [HGT_W-1:0] h_eff;
    logic [HGT_W-1:0] h_even;
    logic [W_W-1:0]   col_ext;
    logic [HGT_W-1:0] row_ext;

    logic             in_area;
    logic             col_end;
    logic             row_end;
    logic             lvl_last;
    logic             accept;
    logic             hold_wr;
    logic             line_wr;
    logic             emit;
    logic             s1_adv;
    logic             out_free;
    logic [ADDR_W-1:0] idx;

    lanes_t           pix;
    lanes_t           pair;
    lanes_t           quad;
    pixel_out_t       dst_next;

    // ---------------- configuration port ----------------

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    // any write to a known register restarts the level
    always_comb
    begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  restart = cfg_wr;
            REG_SRC_HEIGHT: restart = cfg_wr;
            REG_SINGLE_CH:  restart = cfg_wr;
            default:        restart = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(2);
            height_reg <= CFG_W'(2);
            single_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_SINGLE_CH:  single_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_SRC_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_SINGLE_CH:  prdata = PDATA_W'(single_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- effective level size ----------------

    // clamp width to 2..MAX_WIDTH and height to 2..MAX_HEIGHT
    assign w_ext = EXT_W'(width_reg);

    always_comb
    begin
        if (w_ext < EXT_W'(2))
            w_eff = W_W'(2);
        else if (w_ext > EXT_W'(MAX_WIDTH))
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = w_ext[W_W-1:0];

        if (height_reg < HGT_W'(2))
            h_eff = HGT_W'(2);
        else if (height_reg > HGT_W'(MAX_HEIGHT))
            h_eff = HGT_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // even part of each dimension, an odd last column or row falls outside it
    assign w_even  = {w_eff[W_W-1:1], 1'b0};
    assign h_even  = {h_eff[HGT_W-1:1], 1'b0};
    assign col_ext = W_W'(col_reg);
    assign row_ext = HGT_W'(row_reg);

    assign in_area  = (col_ext < w_even) && (row_ext < h_even);
    assign col_end  = (col_ext == w_eff - W_W'(1));
    assign row_end  = (row_ext == h_eff - HGT_W'(1));
    assign lvl_last = (col_ext == w_even - W_W'(1)) && (row_ext == h_even - HGT_W'(1));

    // ---------------- source side ----------------

    assign accept  = src_valid && src_ready;
    assign hold_wr = accept && in_area && !col_reg[0];
    assign line_wr = accept && in_area && col_reg[0] && !row_reg[0];
    assign emit    = accept && in_area && col_reg[0] && row_reg[0];
    assign idx     = col_reg[COL_W-1:1];

    // channels 1..3 read as zero in single-channel mode
    always_comb
    begin
        pix[0] = {1'b0, src_pixel.chan0_in};
        pix[1] = single_reg ? '0 : {1'b0, src_pixel.chan1_in};
        pix[2] = single_reg ? '0 : {1'b0, src_pixel.chan2_in};
        pix[3] = single_reg ? '0 : {1'b0, src_pixel.chan3_in};
    end

    // horizontal pair sum of the held even-column pixel and this one
    assign pair = lane_add(hold_reg, pix);

    // raster position, wraps to a new level after the last source pixel
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        hold_next = hold_reg;
        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            hold_next = '0;
        end
        else if (accept)
        begin
            if (hold_wr)
                hold_next = pix;
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            hold_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            hold_reg <= hold_next;
        end
    end

    // line store: even rows write pair sums, odd rows read the row above
    always_ff @(posedge clk)
    begin
        if (line_wr)
            line_mem[idx] <= pair;
        if (emit)
            above_reg <= line_mem[idx];
    end

    // ---------------- first stage ----------------

    assign out_free  = !dst_valid_reg || dst_ready;
    assign s1_adv    = s1_vld_reg && out_free;
    assign src_ready = !s1_vld_reg || out_free;

    always_comb
    begin
        if (emit)
            s1_vld_next = 1'b1;
        else if (s1_adv)
            s1_vld_next = 1'b0;
        else
            s1_vld_next = s1_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s1_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pair_reg <= pair;
            last_reg <= lvl_last;
        end
    end

    // ---------------- four-pixel sum, divide by four ----------------

    always_comb
    begin
        quad = '0;
        for (int c = 0; c < NUM_LANES; c++)
        begin
            quad[c] = LANE_W'(({1'b0, above_reg[c]} + {1'b0, pair_reg[c]}) >> 2);
        end
        dst_next.chan0_out  = quad[0][PIX_W-1:0];
        dst_next.chan1_out  = single_reg ? '0 : quad[1][PIX_W-1:0];
        dst_next.chan2_out  = single_reg ? '0 : quad[2][PIX_W-1:0];
        dst_next.chan3_out  = single_reg ? '0 : quad[3][PIX_W-1:0];
        dst_next.level_done = last_reg;
    end

    // ---------------- output register ----------------

    always_comb
    begin
        if (s1_adv)
            dst_valid_next = 1'b1;
        else if (dst_ready)
            dst_valid_next = 1'b0;
        else
            dst_valid_next = dst_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_valid_reg <= 1'b0;
        else
            dst_valid_reg <= dst_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            dst_reg <= dst_next;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_pixel = dst_reg;

endmodule

// ===== rtl/mbd_checker.sv =====
`include "assert_macros.svh"

module mbd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                src_valid,
    input logic                src_ready,
    input logic                dst_valid,
    input logic                dst_ready,
    input mbd_pkg::pixel_out_t dst_pixel,
    input logic                psel,
    input logic                pready
);

    // a stalled output transfer keeps its pixel
    `ASSERT_NEXT(a_dst_hold, clk, rst_n, dst_valid && !dst_ready, dst_valid && $stable(dst_pixel))

    // no wait states on the register port
    `ASSERT_IMPL(a_pready, clk, rst_n, psel, pready)

    // an empty output register never blocks the source side
    `ASSERT_IMPL(a_src_open, clk, rst_n, !dst_valid, src_ready)

    // a new output pixel follows an earlier source transfer
    `ASSERT_IMPL(a_dst_latency, clk, rst_n, $rose(dst_valid), $past(src_valid && src_ready, 2))

endmodule

bind mipmap_box_downsample mbd_checker u_mbd_checker (.*);
